/* hw/rtl/mmd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmd_pkg
// shared types, constants and helpers of the min/max decimator
// ----------------------------------------------------------------------------
package mmd_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = 4;
  localparam int FPB_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int FIFO_DEPTH   = 2;
  localparam int LVL_W        = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_BLOCK = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] CHCNT_RESET = CNT_W'(1);
  localparam logic [FPB_W-1:0] FPB_RESET   = FPB_W'(1000);

  localparam sample_t SEED_MIN = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam sample_t SEED_MAX = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

  // one tracker entry: running min and max of a channel
  typedef struct packed {
    sample_t min_v;
    sample_t max_v;
  } entry_t;

  localparam entry_t SEED_ENTRY = {SEED_MIN, SEED_MAX};

  // one result beat
  typedef struct packed {
    sample_t           value;
    logic              is_maximum;
    logic [CH_W-1:0]   channel_index;
    logic              last_of_run;
  } result_t;

  // channel count as used: zero counts as one, saturate at the channel limit
  function automatic logic [CNT_W-1:0] live_channels(input logic [CNT_W-1:0] cc);
    logic [CNT_W-1:0] n;
    n = cc;
    if (cc == '0) begin
      n = CNT_W'(1);
    end else if (cc > CNT_W'(MAX_CHANNELS)) begin
      n = CNT_W'(MAX_CHANNELS);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/mmd_env_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmd_env_ram
// tracker memory: one entry per channel, one write and one read port,
// registered read data
// ----------------------------------------------------------------------------
module mmd_env_ram (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [mmd_pkg::CH_W-1:0] wr_addr,
  input  mmd_pkg::entry_t          wr_data,
  input  logic                     rd_en,
  input  logic [mmd_pkg::CH_W-1:0] rd_addr,
  output mmd_pkg::entry_t          rd_data
);
  import mmd_pkg::*;

  entry_t mem [MAX_CHANNELS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/mmd_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmd_out_fifo
// two-entry result queue in front of the output channel
// ----------------------------------------------------------------------------
module mmd_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  mmd_pkg::result_t          push_data,
  output logic [mmd_pkg::LVL_W-1:0] level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mmd_pkg::result_t          head
);
  import mmd_pkg::*;

  result_t          slot_r [FIFO_DEPTH];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [LVL_W-1:0] level_r;
  logic             pop;

  assign out_valid = (level_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = slot_r[rd_ptr_r];
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        level_r <= level_r + LVL_W'(1);
      end else if (pop && !push) begin
        level_r <= level_r - LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // the flush sequencer counts reads in flight, so a push never finds it full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (level_r != LVL_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

endmodule

/* hw/rtl/minmax_decimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_decimator
// min/max envelope decimator for channel-interleaved Q1.15 audio
// ----------------------------------------------------------------------------
// Samples come in interleave order, one per beat, and the block folds each
// into the running minimum and maximum of its channel. Outside a flush it
// takes one sample per clock: the sample's tracker entry is read from a small
// memory at the accept edge and the updated entry is written back on the
// next cycle, with a one-deep bypass when back-to-back samples hit the same
// channel. When a block of frames_per_block frames completes, or a frame's
// last channel carries end_of_data, the block emits all minima in channel
// order, then all maxima, flags the last one, and re-seeds the trackers.
// During that flush the input is held off, from the update stage of the
// block-ending sample until the last read is issued, as the single read port
// of the tracker memory feeds a two-entry result queue; a stalled output
// stretches it further. Re-seeding is done by clearing per-channel valid
// bits, which make an unwritten entry read as the seed values. Writing either
// register restarts the block and drops any partial block; write only while
// the block is idle.
// ----------------------------------------------------------------------------
module minmax_decimator (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mmd_pkg::sample_t              in_sample,
  input  logic                          in_end_of_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output mmd_pkg::sample_t              out_value,
  output logic                          out_is_maximum,
  output logic [mmd_pkg::CH_W-1:0]      out_channel_index,
  output logic                          out_last_of_run,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mmd_pkg::*;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    chcnt_r;
  logic [FPB_W-1:0]    fpb_r;
  logic [CH_W-1:0]     cur_ch_r;
  logic [FPB_W-1:0]    frames_r;
  logic [MAX_CHANNELS-1:0] seen_r;    // entry written since the last re-seed
  logic                s1_vld_r;      // update stage busy
  logic                s1_end_r;      // sample in update stage closes a block
  logic                wr_hit_r;      // update stage must bypass the memory
  logic                fl_phase_r;    // 0 while emitting minima, 1 for maxima
  logic [CH_W-1:0]     fl_ch_r;
  logic                rd_pend_r;     // flush read data lands this cycle

  // payload registers
  logic [CH_W-1:0]     s1_ch_r;
  sample_t             s1_sample_r;
  logic                s1_seen_r;
  entry_t              wr_data_r;
  logic [CH_W-1:0]     pend_ch_r;
  logic                pend_max_r;
  logic                pend_last_r;
  logic                pend_seen_r;

  // datapath wires
  logic [CNT_W-1:0]    n_live;
  logic [CNT_W-1:0]    n_m1;
  logic [FPB_W-1:0]    fpb_live;
  logic [CH_W-1:0]     ch_acc;
  logic                last_ch;
  logic [FPB_W:0]      frames_inc;
  logic                blk_end;
  logic                in_acc;
  logic                cfg_acc;
  logic                cfg_hit;
  entry_t              ram_rdata;
  entry_t              old_ent;
  entry_t              upd_ent;
  entry_t              pend_ent;
  logic                fl_issue;
  logic                fl_last_ch;
  logic                fl_done;
  logic                ram_re;
  logic [CH_W-1:0]     ram_raddr;
  logic [LVL_W-1:0]    fifo_level;
  result_t             push_data;
  result_t             head;

  // ---- live configuration --------------------------------------------------
  assign n_live   = live_channels(chcnt_r);
  assign n_m1     = n_live - CNT_W'(1);
  assign fpb_live = (fpb_r == '0) ? FPB_W'(1) : fpb_r;

  // ---- accept stage: position in frame and block ---------------------------
  assign ch_acc     = ({1'b0, cur_ch_r} >= n_live) ? n_m1[CH_W-1:0] : cur_ch_r;
  assign last_ch    = (({1'b0, ch_acc} + CNT_W'(1)) == n_live);
  assign frames_inc = {1'b0, frames_r} + (FPB_W+1)'(1);
  // end of data only counts on a frame's last channel
  assign blk_end    = last_ch && ((frames_inc >= {1'b0, fpb_live}) || in_end_of_data);

  // hold off the next sample once a block-ending sample is in the update stage
  assign in_ready = (state_r == ST_RUN) && !(s1_vld_r && s1_end_r);
  assign in_acc   = in_valid && in_ready;

  assign cfg_ready = (state_r == ST_RUN) && !s1_vld_r && !rd_pend_r;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc &&
                     ((cfg_index == CFG_CHANNEL_COUNT) || (cfg_index == CFG_FRAMES_PER_BLOCK));

  // ---- update stage: read-modify-write of the channel entry ----------------
  always_comb begin
    if (wr_hit_r) begin
      old_ent = wr_data_r;
    end else if (s1_seen_r) begin
      old_ent = ram_rdata;
    end else begin
      old_ent = SEED_ENTRY;
    end
    upd_ent.min_v = (s1_sample_r < old_ent.min_v) ? s1_sample_r : old_ent.min_v;
    upd_ent.max_v = (s1_sample_r > old_ent.max_v) ? s1_sample_r : old_ent.max_v;
  end

  // ---- flush sequencer ------------------------------------------------------
  // a read is issued only if the queue has room for it and the one in flight
  assign fl_issue   = (state_r == ST_FLUSH) &&
                      (({1'b0, fifo_level} + (LVL_W+1)'(rd_pend_r)) < (LVL_W+1)'(FIFO_DEPTH));
  assign fl_last_ch = (({1'b0, fl_ch_r} + CNT_W'(1)) == n_live);
  assign fl_done    = fl_issue && fl_phase_r && fl_last_ch;

  // one read port shared by accept and flush, never both in one cycle
  assign ram_re    = in_acc || fl_issue;
  assign ram_raddr = fl_issue ? fl_ch_r : ch_acc;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (s1_vld_r && s1_end_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (fl_done) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      chcnt_r    <= CHCNT_RESET;
      fpb_r      <= FPB_RESET;
      cur_ch_r   <= '0;
      frames_r   <= '0;
      seen_r     <= '0;
      s1_vld_r   <= 1'b0;
      s1_end_r   <= 1'b0;
      wr_hit_r   <= 1'b0;
      fl_phase_r <= 1'b0;
      fl_ch_r    <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_CHANNEL_COUNT:    chcnt_r <= cfg_wdata[CNT_W-1:0];
          CFG_FRAMES_PER_BLOCK: fpb_r   <= cfg_wdata[FPB_W-1:0];
          default: ;
        endcase
      end

      // frame and block counters
      if (cfg_hit) begin
        cur_ch_r <= '0;
        frames_r <= '0;
      end else if (in_acc) begin
        if (last_ch) begin
          cur_ch_r <= '0;
          frames_r <= blk_end ? '0 : frames_inc[FPB_W-1:0];
        end else begin
          cur_ch_r <= ch_acc + CH_W'(1);
        end
      end

      // re-seed by dropping the valid bits
      if (cfg_hit || fl_done) begin
        seen_r <= '0;
      end else if (s1_vld_r) begin
        seen_r[s1_ch_r] <= 1'b1;
      end

      s1_vld_r <= in_acc;
      s1_end_r <= in_acc && blk_end;
      // write-back and read of the same entry meet at this edge
      wr_hit_r <= s1_vld_r && in_acc && (s1_ch_r == ch_acc);

      if (fl_issue) begin
        if (fl_last_ch) begin
          fl_ch_r    <= '0;
          fl_phase_r <= ~fl_phase_r;
        end else begin
          fl_ch_r <= fl_ch_r + CH_W'(1);
        end
      end
      rd_pend_r <= fl_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r     <= ch_acc;
      s1_sample_r <= in_sample;
      s1_seen_r   <= seen_r[ch_acc];
    end
    if (s1_vld_r) begin
      wr_data_r <= upd_ent;
    end
    if (fl_issue) begin
      pend_ch_r   <= fl_ch_r;
      pend_max_r  <= fl_phase_r;
      pend_last_r <= fl_done;
      pend_seen_r <= seen_r[fl_ch_r];
    end
  end

  mmd_env_ram u_ram (
    .clk     (clk),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_ch_r),
    .wr_data (upd_ent),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // ---- result beat assembly -------------------------------------------------
  always_comb begin
    pend_ent                = pend_seen_r ? ram_rdata : SEED_ENTRY;
    push_data.value         = pend_max_r ? pend_ent.max_v : pend_ent.min_v;
    push_data.is_maximum    = pend_max_r;
    push_data.channel_index = pend_ch_r;
    push_data.last_of_run   = pend_last_r;
  end

  mmd_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_pend_r),
    .push_data (push_data),
    .level     (fifo_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_value         = head.value;
  assign out_is_maximum    = head.is_maximum;
  assign out_channel_index = head.channel_index;
  assign out_last_of_run   = head.last_of_run;

  // ---- checks -----------------------------------------------------------------
  a_end_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_end_r) |=> (state_r == ST_FLUSH))
    else $error("block end did not start a flush");

  a_bypass_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_hit_r |-> $past(s1_vld_r))
    else $error("bypass taken without a write-back");

  a_pend_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == ST_FLUSH))
    else $error("flush read data outside a flush");

  a_flush_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> !s1_vld_r)
    else $error("update stage busy during flush");

endmodule

/* sim/minmax_decimator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_decimator_tb
// self-checking bench for the min/max envelope decimator
// ----------------------------------------------------------------------------
// An envelope predictor inside the bench folds every accepted sample beat into
// its own copy of the per-channel trackers and queues the extremes that each
// finished block has to produce. A monitor pops that queue on every result
// beat and compares it field by field. Directed tests cover reset values,
// register corner cases, full-scale samples and block restarts; a random
// phase then sweeps register settings and traffic with gaps on both sides.
// ----------------------------------------------------------------------------
module minmax_decimator_tb;
  import mmd_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 8;      // write-back comes in the cycle after the accept
  localparam int END_CYCLES     = 40;     // settle time after the last result at the end of the run
  localparam int LIMIT_CYCLES   = 300000;
  localparam int RANDOM_SAMPLES = 424;
  localparam int MAX_IDLE       = 12;
  localparam int REPORT_CAP     = 200;

  // register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  // register values after reset
  localparam logic [CNT_W-1:0] RESET_CHANNELS = CNT_W'(1);
  localparam logic [FPB_W-1:0] RESET_FRAMES   = FPB_W'(1000);

  // full-scale Q1.15 values
  localparam sample_t Q15_MIN = sample_t'(16'h8000);
  localparam sample_t Q15_MAX = sample_t'(16'h7fff);

  // dut ports, every input known from time zero
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  sample_t               in_sample      = '0;
  logic                  in_end_of_data = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  sample_t               out_value;
  logic                  out_is_maximum;
  logic [CH_W-1:0]       out_channel_index;
  logic                  out_last_of_run;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

  // idle limits for the sample sender and the result receiver
  int in_gap_max    = 0;
  int out_stall_max = 0;

  // predictor state: registers, trackers and position in the block
  logic [CNT_W-1:0] chan_reg;
  logic [FPB_W-1:0] block_reg;
  sample_t          lo_track [MAX_CHANNELS];
  sample_t          hi_track [MAX_CHANNELS];
  int               chan_pos;
  int               frames_seen;
  result_t          expected_extremes [$];

  int mismatches       = 0;
  int samples_sent     = 0;
  int extremes_checked = 0;
  int reg_writes       = 0;
  int cycle_count      = 0;

  minmax_decimator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_end_of_data    (in_end_of_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value         (out_value),
    .out_is_maximum    (out_is_maximum),
    .out_channel_index (out_channel_index),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("minmax_decimator_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // new block: trackers back to their seeds, counters cleared
  function automatic void reseed_trackers();
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      lo_track[c] = Q15_MAX;
      hi_track[c] = Q15_MIN;
    end
    chan_pos    = 0;
    frames_seen = 0;
  endfunction

  function automatic void write_model_register(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CHANNEL_COUNT: begin
        chan_reg = data[CNT_W-1:0];
        reseed_trackers();
      end
      CFG_FRAMES_PER_BLOCK: begin
        block_reg = data[FPB_W-1:0];
        reseed_trackers();
      end
      default: begin
        // unlisted index: no register, no restart
      end
    endcase
  endfunction

  // fold one sample beat into its channel; a finished block queues its run
  function automatic void fold_sample(input sample_t s, input logic eod);
    int      n;
    int      ch;
    int      blk;
    result_t r;
    // zero channels act as one, anything past eight saturates
    if (chan_reg == '0) n = 1;
    else if (int'(chan_reg) > MAX_CHANNELS) n = MAX_CHANNELS;
    else n = int'(chan_reg);
    ch = (chan_pos >= n) ? n - 1 : chan_pos;
    if (s < lo_track[ch]) lo_track[ch] = s;
    if (s > hi_track[ch]) hi_track[ch] = s;
    // end of data only counts on a frame's last channel
    if (ch + 1 < n) begin
      chan_pos = ch + 1;
      return;
    end
    chan_pos = 0;
    frames_seen++;
    blk = (block_reg == '0) ? 1 : int'(block_reg);
    if (frames_seen < blk && !eod) return;
    // minima in channel order, then maxima, last one flagged
    for (int c = 0; c < n; c++) begin
      r.value         = lo_track[c];
      r.is_maximum    = 1'b0;
      r.channel_index = CH_W'(c);
      r.last_of_run   = 1'b0;
      expected_extremes.push_back(r);
    end
    for (int c = 0; c < n; c++) begin
      r.value         = hi_track[c];
      r.is_maximum    = 1'b1;
      r.channel_index = CH_W'(c);
      r.last_of_run   = (c == n - 1);
      expected_extremes.push_back(r);
    end
    reseed_trackers();
  endfunction

  // ------------------------------------------------------------ result checks

  function automatic void check_field(input string what,
                                      input logic signed [31:0] want_v,
                                      input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endfunction

  // every result beat is matched against the oldest queued extreme
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_extremes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: result beat with none expected, expected none, got %0d/%0b/%0d/%0b",
                   $time, out_value, out_is_maximum, out_channel_index, out_last_of_run);
      end else begin
        want = expected_extremes.pop_front();
        check_field("value", want.value, out_value);
        check_field("is_maximum", want.is_maximum, out_is_maximum);
        check_field("channel_index", want.channel_index, out_channel_index);
        check_field("last_of_run", want.last_of_run, out_last_of_run);
        extremes_checked++;
      end
    end
  end

  // receiver: a fresh stall draw for every result beat
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // ------------------------------------------------------------ drive helpers

  // one sample beat; valid stays high across back-to-back beats
  task automatic send_sample(input sample_t s, input logic eod);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_end_of_data <= eod;
    do @(posedge clk); while (in_ready !== 1'b1);
    fold_sample(s, eod);
    samples_sent++;
  endtask

  // hold the sender until every queued extreme is out, then let the block settle
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_extremes.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    write_model_register(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return Q15_MIN;
      1: return Q15_MAX;
      2: return sample_t'(int'($urandom_range(0, 6)) - 3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int pick_idle_limit();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return MAX_IDLE;
    endcase
  endfunction

  // -------------------------------------------------------------------- tests

  // one channel, 1000-frame blocks: only end of data flushes here
  task automatic test_reset_values();
    in_gap_max    = 0;
    out_stall_max = 0;
    send_sample(Q15_MIN, 1'b1);
    send_sample(Q15_MAX, 1'b0);
    send_sample(sample_t'(-1), 1'b1);
    wait_idle(SETTLE_CYCLES);
  endtask

  // zero in both registers behaves as one channel, one frame
  task automatic test_zero_registers();
    out_stall_max = MAX_IDLE;
    write_register(CFG_CHANNEL_COUNT, 16'h0000);
    write_register(CFG_FRAMES_PER_BLOCK, 16'h0000);
    send_sample(Q15_MAX, 1'b0);
    send_sample(Q15_MIN, 1'b0);
    wait_idle(SETTLE_CYCLES);
  endtask

  // channel count twelve with junk upper bits saturates to eight: 16 results
  task automatic test_channel_saturation();
    in_gap_max    = 3;
    out_stall_max = 3;
    write_register(CFG_CHANNEL_COUNT, 16'ha00c);
    write_register(CFG_FRAMES_PER_BLOCK, 16'h0001);
    for (int c = 0; c < MAX_CHANNELS; c++)
      send_sample(c[0] ? Q15_MAX : Q15_MIN, 1'b0);
    wait_idle(SETTLE_CYCLES);
  endtask

  // end of data on a frame's first channel is ignored
  task automatic test_early_end_of_data();
    in_gap_max    = 0;
    out_stall_max = MAX_IDLE;
    write_register(CFG_CHANNEL_COUNT, 16'h0002);
    write_register(CFG_FRAMES_PER_BLOCK, 16'd500);
    send_sample(sample_t'(16'h1234), 1'b1);
    send_sample(sample_t'(16'hedcb), 1'b0);
    send_sample(sample_t'(16'h0001), 1'b0);
    send_sample(sample_t'(16'hfffe), 1'b1);
    wait_idle(SETTLE_CYCLES);
  endtask

  // largest block size, cut short by end of data
  task automatic test_longest_block();
    write_register(CFG_CHANNEL_COUNT, 16'h5551);
    write_register(CFG_FRAMES_PER_BLOCK, 16'hffff);
    send_sample(Q15_MAX, 1'b0);
    send_sample(Q15_MIN, 1'b1);
    wait_idle(SETTLE_CYCLES);
  endtask

  // a partial block survives an unlisted index but not a real register write
  task automatic test_restart_and_spare_index();
    in_gap_max    = MAX_IDLE;
    out_stall_max = 0;
    write_register(CFG_CHANNEL_COUNT, 16'h0002);
    write_register(CFG_FRAMES_PER_BLOCK, 16'h0002);
    send_sample(sample_t'(16'h0100), 1'b0);
    send_sample(sample_t'(16'hff00), 1'b0);
    send_sample(sample_t'(16'h0200), 1'b0);
    wait_idle(SETTLE_CYCLES);
    write_register(CFG_SPARE_A, 16'hffff);
    send_sample(sample_t'(16'hfe00), 1'b0);
    send_sample(sample_t'(16'h4000), 1'b0);
    wait_idle(SETTLE_CYCLES);
    write_register(CFG_SPARE_B, 16'h0001);
    write_register(CFG_FRAMES_PER_BLOCK, 16'h0003);
    send_sample(sample_t'(16'h0007), 1'b0);
    send_sample(sample_t'(16'hfff9), 1'b1);
    wait_idle(SETTLE_CYCLES);
  endtask

  // random settings per phase, random samples, end of data and pauses
  task automatic test_random_traffic();
    int                    start_count;
    int                    burst;
    logic [CNT_W-1:0]      cc;
    logic [FPB_W-1:0]      fpb;
    logic [CFG_DATA_W-1:0] cc_word;
    start_count = samples_sent;
    while (samples_sent - start_count < RANDOM_SAMPLES) begin
      wait_idle(SETTLE_CYCLES);
      case ($urandom_range(0, 5))
        0: cc = CNT_W'(0);
        1: cc = CNT_W'(MAX_CHANNELS);
        2: cc = CNT_W'($urandom_range(MAX_CHANNELS + 1, 15));
        default: cc = CNT_W'($urandom_range(1, MAX_CHANNELS));
      endcase
      case ($urandom_range(0, 9))
        0: fpb = '0;
        1: fpb = '1;
        2: fpb = FPB_W'($urandom_range(20, 200));
        default: fpb = FPB_W'($urandom_range(1, 6));
      endcase
      // random upper bits exercise the masking of the channel count
      cc_word             = CFG_DATA_W'($urandom);
      cc_word[CNT_W-1:0]  = cc;
      if ($urandom_range(0, 3) == 0)
        write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                       CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) begin
        write_register(CFG_CHANNEL_COUNT, cc_word);
        write_register(CFG_FRAMES_PER_BLOCK, fpb);
      end else begin
        write_register(CFG_FRAMES_PER_BLOCK, fpb);
        write_register(CFG_CHANNEL_COUNT, cc_word);
      end
      in_gap_max    = pick_idle_limit();
      out_stall_max = pick_idle_limit();
      burst         = $urandom_range(16, 64);
      repeat (burst) begin
        // now and then the sender waits for the pipe to drain mid-block
        if ($urandom_range(0, 31) == 0) wait_idle(0);
        send_sample(pick_sample(), $urandom_range(0, 11) == 0);
      end
    end
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    chan_reg  = RESET_CHANNELS;
    block_reg = RESET_FRAMES;
    reseed_trackers();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_zero_registers();
    test_channel_saturation();
    test_early_end_of_data();
    test_longest_block();
    test_restart_and_spare_index();
    test_random_traffic();

    wait_idle(END_CYCLES);
    $display("run: %0d samples in, %0d extremes compared, %0d register writes, %0d cycles",
             samples_sent, extremes_checked, reg_writes, cycle_count);
    $display("run: channel counts 0..15, block sizes 0..65535, early and late end of data");
    if (mismatches == 0) begin
      $display("minmax_decimator_tb OK");
    end else begin
      $display("minmax_decimator_tb NOT OK");
    end
    $finish;
  end

endmodule
